[rtl/assert_macros.svh]
// assertion macros used by the top level rtl module of the memory map decoder
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BMMD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define BMMD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define BMMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BMMD_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define BMMD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BMMD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/bmmd_pkg.sv]
// types, codes and address constants of the banked memory map decoder
// no dependencies; used by bmmd_decode and banked_memory_map_decoder
`default_nettype none

package bmmd_pkg;

    localparam int MEM_DEPTH    = 65536;
    localparam int DRIVER_DEPTH = 256;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);
    localparam int DRV_AW       = $clog2(DRIVER_DEPTH);

    // opcodes
    localparam logic [2:0] OP_FETCH     = 3'd0;
    localparam logic [2:0] OP_READ      = 3'd1;
    localparam logic [2:0] OP_WRITE     = 3'd2;
    localparam logic [2:0] OP_JUMP      = 3'd3;
    localparam logic [2:0] OP_LOAD_RAM  = 3'd4;
    localparam logic [2:0] OP_LOAD_ROM  = 3'd5;
    localparam logic [2:0] OP_LOAD_DRV  = 3'd6;

    // environment modes
    localparam logic [1:0] ENV_PLAYSID  = 2'd0;
    localparam logic [1:0] ENV_TRANSP   = 2'd1;
    localparam logic [1:0] ENV_BANKED   = 2'd2;
    localparam logic [1:0] ENV_REAL     = 2'd3;

    // result targets
    localparam logic [2:0] TGT_MEM      = 3'd0;
    localparam logic [2:0] TGT_SID      = 3'd1;
    localparam logic [2:0] TGT_SID2     = 3'd2;
    localparam logic [2:0] TGT_XSID     = 3'd3;
    localparam logic [2:0] TGT_CIA1     = 3'd4;
    localparam logic [2:0] TGT_CIA2     = 3'd5;
    localparam logic [2:0] TGT_VIC      = 3'd6;

    // read data sources
    localparam logic [2:0] SRC_NONE     = 3'd0;
    localparam logic [2:0] SRC_RAM      = 3'd1;
    localparam logic [2:0] SRC_ROM      = 3'd2;
    localparam logic [2:0] SRC_DRV      = 3'd3;
    localparam logic [2:0] SRC_BANK     = 3'd4;

    // write destinations
    localparam logic [1:0] MEM_NONE     = 2'd0;
    localparam logic [1:0] MEM_RAM      = 2'd1;
    localparam logic [1:0] MEM_ROM      = 2'd2;
    localparam logic [1:0] MEM_DRV      = 2'd3;

    // configuration register index (paddr bit 2)
    localparam logic       REG_ENV      = 1'b0;
    localparam logic       REG_SSID     = 1'b1;

    // address map
    localparam logic [15:0] SID_MASK     = 16'hfc1f;
    localparam logic [7:0]  SID_PAGE     = 8'hd4;
    localparam logic [15:0] SID_BASE     = 16'hd400;
    localparam logic [7:0]  XSID_FIRST   = 8'h1d;
    localparam logic [7:0]  CIA1_PAGE    = 8'hdc;
    localparam logic [7:0]  CIA2_PAGE    = 8'hdd;
    localparam logic [15:0] VIC_MASK     = 16'hfc00;
    localparam logic [15:0] VIC_BASE     = 16'hd000;
    localparam logic [3:0]  CIA_REG_MASK = 4'hf;
    localparam logic [5:0]  VIC_REG_MASK = 6'h3f;
    localparam logic [15:0] BASIC_BASE   = 16'ha000;
    localparam logic [15:0] IO_BASE      = 16'hd000;
    localparam logic [15:0] BANK_ADDR    = 16'h0001;
    localparam logic [15:0] DRIVER_LIMIT = 16'h0100;
    localparam logic [7:0]  BANK_RESET   = 8'h07;

    // decoder context: configuration and banking state
    typedef struct packed {
        logic [1:0] env;
        logic [7:0] ssid;
        logic [7:0] bank;
        logic       dp_active;
    } t_ctx;

    // one decoded access
    typedef struct packed {
        logic        has_res;
        logic        two_res;
        logic [2:0]  rd_src;
        logic [15:0] rd_addr;
        logic [1:0]  wr_mem;
        logic [15:0] wr_addr;
        logic        wr2;
        logic [1:0]  wr2_mem;
        logic [15:0] wr2_addr;
        logic        bank_we;
        logic        dp_we;
        logic        dp_val;
        logic [2:0]  target;
        logic [15:0] dev_reg;
        logic        dev_wr;
        logic [7:0]  dev_data;
        logic        jump;
        logic [7:0]  reg2;
    } t_dec;

endpackage

`default_nettype wire

[rtl/bmmd_ram.sv]
// generic single write port ram with registered, enabled read
// no dependencies
`default_nettype none

module bmmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/bmmd_decode.sv]
// combinational access decoder: address map, banking and device routing
// depends on bmmd_pkg
`default_nettype none

module bmmd_decode (
    input  wire logic [2:0]     i_opcode,
    input  wire logic [15:0]    i_address,
    input  wire logic [7:0]     i_write_data,
    input  wire logic           i_use_cache,
    input  wire bmmd_pkg::t_ctx i_ctx,
    output bmmd_pkg::t_dec      o_dec
);

    logic w_basic;
    logic w_io;
    logic w_kernal;

    assign w_basic  = (i_ctx.bank[1:0] == 2'b11);
    assign w_io     = (i_ctx.bank[2:0] > 3'd4);
    assign w_kernal = i_ctx.bank[1];

    function automatic logic [2:0] rom_src();
        return (i_ctx.env == bmmd_pkg::ENV_PLAYSID) ? bmmd_pkg::SRC_RAM : bmmd_pkg::SRC_ROM;
    endfunction

    function automatic logic [1:0] rom_mem();
        return (i_ctx.env == bmmd_pkg::ENV_PLAYSID) ? bmmd_pkg::MEM_RAM : bmmd_pkg::MEM_ROM;
    endfunction

    function automatic bmmd_pkg::t_dec mem_rd(input logic [2:0] src, input logic [15:0] a);
        bmmd_pkg::t_dec x;
        x         = '0;
        x.has_res = 1'b1;
        x.rd_src  = src;
        x.rd_addr = a;
        return x;
    endfunction

    function automatic bmmd_pkg::t_dec mem_ack();
        bmmd_pkg::t_dec x;
        x         = '0;
        x.has_res = 1'b1;
        return x;
    endfunction

    function automatic bmmd_pkg::t_dec dev(input logic [2:0] tgt, input logic [15:0] r,
                                           input logic wr, input logic [7:0] d);
        bmmd_pkg::t_dec x;
        x          = '0;
        x.has_res  = 1'b1;
        x.target   = tgt;
        x.dev_reg  = r;
        x.dev_wr   = wr;
        x.dev_data = d;
        return x;
    endfunction

    function automatic bmmd_pkg::t_dec plain_rd(input logic [15:0] a, input logic dp);
        if (a == bmmd_pkg::BANK_ADDR) begin
            return mem_rd(bmmd_pkg::SRC_BANK, a);
        end else if (dp && a < bmmd_pkg::DRIVER_LIMIT) begin
            return mem_rd(bmmd_pkg::SRC_DRV, a);
        end
        return mem_rd(bmmd_pkg::SRC_RAM, a);
    endfunction

    function automatic bmmd_pkg::t_dec plain_wr(input logic [15:0] a, input logic dp);
        bmmd_pkg::t_dec x;
        x = mem_ack();
        if (dp && a < bmmd_pkg::DRIVER_LIMIT) begin
            x.wr_mem  = bmmd_pkg::MEM_DRV;
            x.wr_addr = a;
            x.bank_we = (a == bmmd_pkg::BANK_ADDR);
        end else if (a == bmmd_pkg::BANK_ADDR) begin
            x.bank_we = 1'b1;
        end else begin
            x.wr_mem  = bmmd_pkg::MEM_RAM;
            x.wr_addr = a;
        end
        return x;
    endfunction

    function automatic bmmd_pkg::t_dec io_rd(input logic [15:0] a, input logic cache,
                                             input logic dp);
        logic [15:0] t;
        t = a & bmmd_pkg::SID_MASK;
        if (t[15:8] != bmmd_pkg::SID_PAGE) begin
            if (a[15:8] == 8'h00) begin
                return plain_rd(a, dp);
            end else if (a[15:8] == bmmd_pkg::CIA1_PAGE) begin
                return dev(bmmd_pkg::TGT_CIA1, {12'h000, a[3:0] & bmmd_pkg::CIA_REG_MASK},
                           1'b0, 8'h00);
            end else if (a[15:8] == bmmd_pkg::CIA2_PAGE) begin
                return dev(bmmd_pkg::TGT_CIA2, {12'h000, a[3:0] & bmmd_pkg::CIA_REG_MASK},
                           1'b0, 8'h00);
            end else if ((a & bmmd_pkg::VIC_MASK) == bmmd_pkg::VIC_BASE) begin
                return dev(bmmd_pkg::TGT_VIC, {10'h000, a[5:0] & bmmd_pkg::VIC_REG_MASK},
                           1'b0, 8'h00);
            end
            return mem_rd(rom_src(), a);
        end
        if (t[7:0] >= bmmd_pkg::XSID_FIRST) begin
            return dev(bmmd_pkg::TGT_XSID, a, 1'b0, 8'h00);
        end
        if (a[15:8] == i_ctx.ssid) begin
            return cache ? mem_rd(rom_src(), a)
                         : dev(bmmd_pkg::TGT_SID2, {8'h00, a[7:0]}, 1'b0, 8'h00);
        end
        return cache ? mem_rd(rom_src(), t)
                     : dev(bmmd_pkg::TGT_SID, {8'h00, t[7:0]}, 1'b0, 8'h00);
    endfunction

    function automatic bmmd_pkg::t_dec io_wr(input logic [15:0] a, input logic [7:0] d,
                                             input logic cache, input logic dp);
        logic [15:0]    t;
        bmmd_pkg::t_dec x;
        t = a & bmmd_pkg::SID_MASK;
        if (t[15:8] != bmmd_pkg::SID_PAGE) begin
            if (a[15:8] == 8'h00) begin
                return plain_wr(a, dp);
            end else if (a[15:8] == bmmd_pkg::CIA1_PAGE) begin
                return dev(bmmd_pkg::TGT_CIA1, {12'h000, a[3:0] & bmmd_pkg::CIA_REG_MASK},
                           1'b1, d);
            end else if (a[15:8] == bmmd_pkg::CIA2_PAGE) begin
                return dev(bmmd_pkg::TGT_CIA2, {12'h000, a[3:0] & bmmd_pkg::CIA_REG_MASK},
                           1'b1, d);
            end else if ((a & bmmd_pkg::VIC_MASK) == bmmd_pkg::VIC_BASE) begin
                return dev(bmmd_pkg::TGT_VIC, {10'h000, a[5:0] & bmmd_pkg::VIC_REG_MASK},
                           1'b1, d);
            end
            x         = mem_ack();
            x.wr_mem  = rom_mem();
            x.wr_addr = a;
            return x;
        end
        if (t[7:0] >= bmmd_pkg::XSID_FIRST) begin
            return dev(bmmd_pkg::TGT_XSID, a - bmmd_pkg::SID_BASE, 1'b1, d);
        end
        if (a[15:8] == i_ctx.ssid) begin
            x = dev(bmmd_pkg::TGT_SID2, {8'h00, a[7:0]}, 1'b1, d);
            if (cache) begin
                x.wr_mem  = rom_mem();
                x.wr_addr = a;
                // mono to stereo: the sid gets the same write right after
                if (i_ctx.ssid == bmmd_pkg::SID_PAGE) begin
                    x.two_res  = 1'b1;
                    x.reg2     = t[7:0];
                    x.wr2      = 1'b1;
                    x.wr2_mem  = rom_mem();
                    x.wr2_addr = t;
                end
            end
            return x;
        end
        x = dev(bmmd_pkg::TGT_SID, {8'h00, t[7:0]}, 1'b1, d);
        if (cache) begin
            x.wr_mem  = rom_mem();
            x.wr_addr = t;
        end
        return x;
    endfunction

    function automatic bmmd_pkg::t_dec bs_rd(input logic [15:0] a, input logic cache,
                                             input logic dp);
        if (a < bmmd_pkg::BASIC_BASE) begin
            return plain_rd(a, dp);
        end else if (a[15:12] == 4'ha || a[15:12] == 4'hb) begin
            return mem_rd(w_basic ? rom_src() : bmmd_pkg::SRC_RAM, a);
        end else if (a[15:12] == 4'hc) begin
            return mem_rd(bmmd_pkg::SRC_RAM, a);
        end else if (a[15:12] == 4'hd) begin
            return w_io ? io_rd(a, cache, dp) : mem_rd(bmmd_pkg::SRC_RAM, a);
        end
        return mem_rd(w_kernal ? rom_src() : bmmd_pkg::SRC_RAM, a);
    endfunction

    function automatic bmmd_pkg::t_dec tp_rd(input logic [15:0] a, input logic cache,
                                             input logic dp);
        if (a < bmmd_pkg::IO_BASE) begin
            return plain_rd(a, dp);
        end else if (a[15:12] == 4'hd && w_io) begin
            return io_rd(a, cache, dp);
        end
        return mem_rd(bmmd_pkg::SRC_RAM, a);
    endfunction

    function automatic bmmd_pkg::t_dec sys_wr(input logic [15:0] a, input logic [7:0] d,
                                              input logic cache, input logic dp);
        bmmd_pkg::t_dec x;
        if (i_ctx.env == bmmd_pkg::ENV_PLAYSID) begin
            return io_wr(a, d, cache, dp);
        end else if (a < bmmd_pkg::BASIC_BASE) begin
            return plain_wr(a, dp);
        end else if (a[15:12] == 4'hd && w_io) begin
            return io_wr(a, d, cache, dp);
        end
        x         = mem_ack();
        x.wr_mem  = bmmd_pkg::MEM_RAM;
        x.wr_addr = a;
        return x;
    endfunction

    function automatic logic jump_ok(input logic [15:0] a);
        if (i_ctx.env == bmmd_pkg::ENV_BANKED && a >= bmmd_pkg::BASIC_BASE) begin
            if ((a[15:12] == 4'ha || a[15:12] == 4'hb) && w_basic) begin
                return 1'b0;
            end
            if (a[15:12] == 4'hd && w_io) begin
                return 1'b0;
            end
            if (a[15:12] >= 4'he && w_kernal) begin
                return 1'b0;
            end
        end else if (i_ctx.env == bmmd_pkg::ENV_TRANSP) begin
            if (a >= bmmd_pkg::IO_BASE && w_kernal) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    logic w_dp_fetch;

    assign w_dp_fetch = (i_address < bmmd_pkg::DRIVER_LIMIT);

    always_comb begin
        o_dec = '0;
        unique case (i_opcode)
            bmmd_pkg::OP_FETCH: begin
                if (i_use_cache) begin
                    o_dec = mem_rd(bmmd_pkg::SRC_RAM, i_address);
                end else begin
                    // the driver page flag follows the fetch and applies to it already
                    o_dec = (i_ctx.env == bmmd_pkg::ENV_REAL) ?
                            bs_rd(i_address, 1'b0, w_dp_fetch) :
                            plain_rd(i_address, w_dp_fetch);
                    o_dec.dp_we  = 1'b1;
                    o_dec.dp_val = w_dp_fetch;
                end
            end
            bmmd_pkg::OP_READ: begin
                if (i_ctx.env == bmmd_pkg::ENV_PLAYSID) begin
                    o_dec = io_rd(i_address, i_use_cache, i_ctx.dp_active);
                end else if (i_ctx.env == bmmd_pkg::ENV_TRANSP) begin
                    o_dec = tp_rd(i_address, i_use_cache, i_ctx.dp_active);
                end else begin
                    o_dec = bs_rd(i_address, i_use_cache, i_ctx.dp_active);
                end
            end
            bmmd_pkg::OP_WRITE: begin
                o_dec = sys_wr(i_address, i_write_data, i_use_cache, i_ctx.dp_active);
            end
            bmmd_pkg::OP_JUMP: begin
                o_dec      = mem_ack();
                o_dec.jump = jump_ok(i_address);
            end
            bmmd_pkg::OP_LOAD_RAM: begin
                o_dec.wr_mem  = bmmd_pkg::MEM_RAM;
                o_dec.wr_addr = i_address;
            end
            bmmd_pkg::OP_LOAD_ROM: begin
                o_dec.wr_mem  = rom_mem();
                o_dec.wr_addr = i_address;
            end
            bmmd_pkg::OP_LOAD_DRV: begin
                o_dec.wr_mem  = bmmd_pkg::MEM_DRV;
                o_dec.wr_addr = i_address;
            end
            default: begin
                o_dec = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/banked_memory_map_decoder.sv]
// an accepted access is registered in stage 1 (with its memory read) and then in the output register
// throughput: one access per cycle while the result channel does not stall; a mono-to-stereo cached sid
//   write gives two results and holds the input until its second result is loaded (second ram write port use)
// image loads produce no result and complete at the accept edge
// reset (i_rst_n low, synchronous): bank register 0x07, driver page flag off,
//   env_mode 2, second sid page 0; memory contents are not cleared
// top level of the banked memory map decoder
// depends on bmmd_pkg, bmmd_decode, bmmd_ram and assert_macros.svh
`default_nettype none

module banked_memory_map_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // access channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    input  wire logic        i_use_cache,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_read_data,
    output logic [2:0]       o_target,
    output logic [15:0]      o_device_register,
    output logic             o_device_is_write,
    output logic [7:0]       o_device_data,
    output logic             o_jump_allowed,
    output logic             o_last
);

    // configuration and banking state
    logic [1:0] r_env;
    logic [7:0] r_ssid;
    logic [7:0] r_bank;
    logic       r_dp_active;

    // stage 1: decoded transaction waiting for the memory read data
    logic            r_s1_valid;
    logic            r_s1_phase;
    bmmd_pkg::t_dec  r_s1_dec;
    logic [7:0]      r_s1_bank;
    logic            r_wr2_pend;

    // output register
    logic        r_o_valid;
    logic [7:0]  r_o_read_data;
    logic [2:0]  r_o_target;
    logic [15:0] r_o_dev_reg;
    logic        r_o_dev_wr;
    logic [7:0]  r_o_dev_data;
    logic        r_o_jump;
    logic        r_o_last;

    logic [7:0]  n_read_data;
    logic [2:0]  n_target;
    logic [15:0] n_dev_reg;
    logic        n_dev_wr;
    logic [7:0]  n_dev_data;
    logic        n_jump;
    logic        n_last;

    bmmd_pkg::t_ctx w_ctx;
    bmmd_pkg::t_dec w_dec;
    logic           w_acc;
    logic           w_out_load;
    logic           w_s1_done;
    logic           w_cfg_we;

    logic                        w_ram_we, w_rom_we, w_drv_we;
    logic                        w_ram_re, w_rom_re, w_drv_re;
    logic [bmmd_pkg::MEM_AW-1:0] w_waddr;
    logic [7:0]                  w_wdata;
    logic [7:0]                  w_ram_rdata, w_rom_rdata, w_drv_rdata;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                bmmd_pkg::REG_ENV:  prdata = {30'h0, r_env};
                bmmd_pkg::REG_SSID: prdata = {24'h0, r_ssid};
                default:            prdata = '0;
            endcase
        end
    end

    // decode
    assign w_ctx.env       = r_env;
    assign w_ctx.ssid      = r_ssid;
    assign w_ctx.bank      = r_bank;
    assign w_ctx.dp_active = r_dp_active;

    bmmd_decode u_decode (
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_use_cache  (i_use_cache),
        .i_ctx        (w_ctx),
        .o_dec        (w_dec)
    );

    // handshake
    assign w_out_load = r_s1_valid && (!r_o_valid || i_out_ready);
    assign w_s1_done  = w_out_load && (!r_s1_dec.two_res || r_s1_phase);
    assign o_in_ready = !r_s1_valid || w_s1_done;
    assign w_acc      = i_in_valid && o_in_ready;

    // memory ports; the second write of a stereo transaction takes the cycle after accept
    assign w_ram_we = (w_acc && w_dec.wr_mem == bmmd_pkg::MEM_RAM) ||
                      (r_wr2_pend && r_s1_dec.wr2_mem == bmmd_pkg::MEM_RAM);
    assign w_rom_we = (w_acc && w_dec.wr_mem == bmmd_pkg::MEM_ROM) ||
                      (r_wr2_pend && r_s1_dec.wr2_mem == bmmd_pkg::MEM_ROM);
    assign w_drv_we = (w_acc && w_dec.wr_mem == bmmd_pkg::MEM_DRV) ||
                      (r_wr2_pend && r_s1_dec.wr2_mem == bmmd_pkg::MEM_DRV);
    assign w_waddr  = r_wr2_pend ? r_s1_dec.wr2_addr : w_dec.wr_addr;
    assign w_wdata  = r_wr2_pend ? r_s1_dec.dev_data : i_write_data;

    assign w_ram_re = w_acc && w_dec.rd_src == bmmd_pkg::SRC_RAM;
    assign w_rom_re = w_acc && w_dec.rd_src == bmmd_pkg::SRC_ROM;
    assign w_drv_re = w_acc && w_dec.rd_src == bmmd_pkg::SRC_DRV;

    bmmd_ram #(.WIDTH(8), .DEPTH(bmmd_pkg::MEM_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_dec.rd_addr),
        .o_rdata (w_ram_rdata)
    );

    bmmd_ram #(.WIDTH(8), .DEPTH(bmmd_pkg::MEM_DEPTH)) u_rom (
        .i_clk   (i_clk),
        .i_we    (w_rom_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_rom_re),
        .i_raddr (w_dec.rd_addr),
        .o_rdata (w_rom_rdata)
    );

    bmmd_ram #(.WIDTH(8), .DEPTH(bmmd_pkg::DRIVER_DEPTH)) u_drv (
        .i_clk   (i_clk),
        .i_we    (w_drv_we),
        .i_waddr (w_waddr[bmmd_pkg::DRV_AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_drv_re),
        .i_raddr (w_dec.rd_addr[bmmd_pkg::DRV_AW-1:0]),
        .o_rdata (w_drv_rdata)
    );

    // state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env       <= bmmd_pkg::ENV_BANKED;
            r_ssid      <= 8'h00;
            r_bank      <= bmmd_pkg::BANK_RESET;
            r_dp_active <= 1'b0;
        end else begin
            if (w_cfg_we) begin
                unique case (paddr[2])
                    bmmd_pkg::REG_ENV:  r_env  <= pwdata[1:0];
                    bmmd_pkg::REG_SSID: r_ssid <= pwdata[7:0];
                    default:            r_env  <= r_env;
                endcase
            end
            if (w_acc && w_dec.bank_we) begin
                r_bank <= i_write_data;
            end
            if (w_acc && w_dec.dp_we) begin
                r_dp_active <= w_dec.dp_val;
            end
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
            r_wr2_pend <= 1'b0;
        end else begin
            r_wr2_pend <= w_acc && w_dec.wr2;
            if (w_acc && w_dec.has_res) begin
                r_s1_valid <= 1'b1;
                r_s1_phase <= 1'b0;
            end else if (w_s1_done) begin
                r_s1_valid <= 1'b0;
            end else if (w_out_load) begin
                r_s1_phase <= 1'b1;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_acc && w_dec.has_res) begin
            r_s1_dec  <= w_dec;
            r_s1_bank <= r_bank;
        end
    end

    // result selection
    always_comb begin
        unique case (r_s1_dec.rd_src)
            bmmd_pkg::SRC_RAM:  n_read_data = w_ram_rdata;
            bmmd_pkg::SRC_ROM:  n_read_data = w_rom_rdata;
            bmmd_pkg::SRC_DRV:  n_read_data = w_drv_rdata;
            bmmd_pkg::SRC_BANK: n_read_data = r_s1_bank;
            default:            n_read_data = 8'h00;
        endcase
        n_target   = r_s1_dec.target;
        n_dev_reg  = r_s1_dec.dev_reg;
        n_dev_wr   = r_s1_dec.dev_wr;
        n_dev_data = r_s1_dec.dev_data;
        n_jump     = r_s1_dec.jump;
        n_last     = !r_s1_dec.two_res;
        // second result of a stereo write goes to the sid
        if (r_s1_phase) begin
            n_read_data = 8'h00;
            n_target    = bmmd_pkg::TGT_SID;
            n_dev_reg   = {8'h00, r_s1_dec.reg2};
            n_dev_wr    = 1'b1;
            n_jump      = 1'b0;
            n_last      = 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_read_data <= n_read_data;
            r_o_target    <= n_target;
            r_o_dev_reg   <= n_dev_reg;
            r_o_dev_wr    <= n_dev_wr;
            r_o_dev_data  <= n_dev_data;
            r_o_jump      <= n_jump;
            r_o_last      <= n_last;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_read_data       = r_o_read_data;
    assign o_target          = r_o_target;
    assign o_device_register = r_o_dev_reg;
    assign o_device_is_write = r_o_dev_wr;
    assign o_device_data     = r_o_dev_data;
    assign o_jump_allowed    = r_o_jump;
    assign o_last            = r_o_last;

    `include "assert_macros.svh"

    `BMMD_ASSERT_IMPLY(a_wr2_owner, i_clk, i_rst_n, r_wr2_pend, r_s1_valid && r_s1_dec.two_res && !r_s1_phase)
    `BMMD_ASSERT_IMPLY(a_wr2_no_accept, i_clk, i_rst_n, r_wr2_pend, !w_acc)
    `BMMD_ASSERT_ALWAYS(a_one_read, i_clk, i_rst_n, $onehot0({w_ram_re, w_rom_re, w_drv_re}))
    `BMMD_ASSERT_ALWAYS(a_one_write, i_clk, i_rst_n, $onehot0({w_ram_we, w_rom_we, w_drv_we}))
    `BMMD_ASSERT_NEXT(a_second_follows, i_clk, i_rst_n, r_o_valid && !r_o_last, r_o_valid)

endmodule

`default_nettype wire
